FILE: design/point_to_pixel_projection_defines.svh
// Assertion macros shared by the projection pipeline.
`ifndef POINT_TO_PIXEL_PROJECTION_DEFINES_SVH
`define POINT_TO_PIXEL_PROJECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define P2P_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("p2p assertion failed");
`define P2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("p2p assertion failed");
`else
`define P2P_ASSERT_NOW(label, ante, cons)
`define P2P_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: design/p2p_pkg.sv
// Shared types, constants and fixed-point helpers of the projection pipeline.
package p2p_pkg;

  localparam int FRAC        = 28;
  localparam int DIV_STAGES  = 33;
  localparam int DIST_STAGES = 15;

  localparam logic signed [31:0] Q_ONE = 32'sh1000_0000;

  typedef enum logic [2:0] {
    REG_K1, REG_K2, REG_K3, REG_P1, REG_P2, REG_FX, REG_FY, REG_PP
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEPTH = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [31:0] k1;
    logic signed [31:0] k2;
    logic signed [31:0] k3;
    logic signed [31:0] p1;
    logic signed [31:0] p2;
    logic        [31:0] fx;
    logic        [31:0] fy;
    logic signed [31:0] ppx;
    logic signed [31:0] ppy;
  } cam_cfg_t;

  typedef struct packed {
    logic               zbad;
    logic               clip;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } pt_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [4:0]  low;
    logic [30:0] rem;
    logic [32:0] q;
  } div_lane_t;

  typedef struct packed {
    logic               zbad;
    logic               clip;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] r2;
    logic signed [31:0] r4;
    logic signed [31:0] r6;
    logic signed [31:0] f;
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [31:0] xx;
    logic signed [31:0] yy;
    logic signed [31:0] xy;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [35:0] t1;
    logic signed [35:0] t2;
    logic signed [63:0] m0;
    logic signed [63:0] m1;
    logic signed [63:0] m2;
    logic signed [63:0] m3;
  } dctx_t;

  typedef struct packed {
    logic               clip;
    logic signed [31:0] v;
  } sat_t;

  function automatic sat_t sat32(input logic signed [39:0] v);
    sat_t s;
    if (v > 40'sd2147483647) begin
      s.clip = 1'b1;
      s.v    = 32'sh7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      s.clip = 1'b1;
      s.v    = 32'sh8000_0000;
    end else begin
      s.clip = 1'b0;
      s.v    = v[31:0];
    end
    return s;
  endfunction

  function automatic logic signed [35:0] fsh(input logic signed [63:0] p);
    return $signed(p[63:FRAC]);
  endfunction

endpackage

FILE: design/point_to_pixel_projection.sv
// Throughput: one point per cycle while the output is not stalled.
// The 33-stage divider and the multiply stages all advance together.
// The whole pipeline holds while a finished pixel waits under stall.
// Reset clears every valid bit and loads the camera registers with their defaults.
`include "point_to_pixel_projection_defines.svh"
module point_to_pixel_projection import p2p_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               pixel_valid,
  input  logic               pixel_stall,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic [1:0]         status
);

  cam_cfg_t cfg;
  logic     adv;
  logic     nvalid;
  pt_t      npt;
  logic     dvalid;
  pt_t      dpt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{k1: '0, k2: '0, k3: '0, p1: '0, p2: '0, fx: 32'd65536, fy: 32'd65536,
               ppx: '0, ppy: '0};
    end else if (cfg_write) begin
      unique case (reg_idx_t'(cfg_index))
        REG_K1: cfg.k1 <= $signed(cfg_data[31:0]);
        REG_K2: cfg.k2 <= $signed(cfg_data[31:0]);
        REG_K3: cfg.k3 <= $signed(cfg_data[31:0]);
        REG_P1: cfg.p1 <= $signed(cfg_data[31:0]);
        REG_P2: cfg.p2 <= $signed(cfg_data[31:0]);
        REG_FX: cfg.fx <= cfg_data[31:0];
        REG_FY: cfg.fy <= cfg_data[31:0];
        REG_PP: begin
          cfg.ppx <= $signed(cfg_data[63:32]);
          cfg.ppy <= $signed(cfg_data[31:0]);
        end
        default: ;
      endcase
    end
  end

  assign adv         = !(pixel_valid && pixel_stall);
  assign point_stall = !adv;

  p2p_norm u_norm (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (point_valid),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .out_valid(nvalid),
    .out_pt   (npt)
  );

  p2p_distort u_distort (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (nvalid),
    .in_pt    (npt),
    .out_valid(dvalid),
    .out_pt   (dpt)
  );

  p2p_pixel u_pixel (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (dvalid),
    .in_pt    (dpt),
    .out_valid(pixel_valid),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .status   (status)
  );

  `P2P_ASSERT_NOW(a_depth_zero, pixel_valid && status == ST_DEPTH, pixel_x == 32'sd0 && pixel_y == 32'sd0)
  `P2P_ASSERT_NOW(a_stall_needs_result, point_stall, pixel_valid)

endmodule

FILE: design/p2p_norm.sv
// Pipelined restoring divider that forms X/Z and Y/Z in Q4.28.
`include "point_to_pixel_projection_defines.svh"
module p2p_norm import p2p_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  output pt_t                out_pt
);

  logic [DIV_STAGES:0] vld;
  div_lane_t           lane [0:DIV_STAGES][0:1];
  logic [30:0]         den  [0:DIV_STAGES];
  logic                zbad [0:DIV_STAGES];

  function automatic div_lane_t lane_init(input logic signed [31:0] p, input logic [30:0] d);
    logic [31:0] mag;
    div_lane_t   l;
    mag   = p[31] ? 32'(-p) : 32'(p);
    l.neg = p[31];
    l.ovf = {4'b0, mag} >= {d, 5'b0};
    l.low = mag[4:0];
    l.rem = {4'b0, mag[31:5]};
    l.q   = '0;
    return l;
  endfunction

  function automatic sat_t lane_result(input div_lane_t l);
    sat_t s;
    if (l.neg) begin
      s.clip = l.ovf || (l.q > {2'b01, 31'b0});
      s.v    = s.clip ? 32'sh8000_0000 : $signed(32'(~l.q[31:0] + 32'd1));
    end else begin
      s.clip = l.ovf || (l.q[32:31] != 2'b00);
      s.v    = s.clip ? 32'sh7fff_ffff : $signed(l.q[31:0]);
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      lane[0][0] <= lane_init(point_x, point_z[30:0]);
      lane[0][1] <= lane_init(point_y, point_z[30:0]);
      den[0]     <= point_z[30:0];
      zbad[0]    <= point_z[31] || (point_z == 32'sd0);
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    localparam int B = DIV_STAGES - k;
    for (genvar j = 0; j < 2; j++) begin : g_lane
      logic        nb;
      logic [31:0] t;
      logic        ge;
      div_lane_t   lane_next;
      if (B >= FRAC) begin : g_bit
        assign nb = lane[k-1][j].low[B-FRAC];
      end else begin : g_zero
        assign nb = 1'b0;
      end
      assign t  = {lane[k-1][j].rem, nb};
      assign ge = t >= {1'b0, den[k-1]};
      always_comb begin
        lane_next     = lane[k-1][j];
        lane_next.rem = ge ? 31'(t - {1'b0, den[k-1]}) : t[30:0];
        lane_next.q   = {lane[k-1][j].q[31:0], ge};
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          lane[k][j] <= lane_next;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        den[k]  <= den[k-1];
        zbad[k] <= zbad[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[DIV_STAGES-1:0], in_valid};
      out_valid <= vld[DIV_STAGES];
    end
  end

  sat_t rx;
  sat_t ry;
  assign rx = lane_result(lane[DIV_STAGES][0]);
  assign ry = lane_result(lane[DIV_STAGES][1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pt.zbad <= zbad[DIV_STAGES];
      out_pt.clip <= rx.clip | ry.clip;
      out_pt.x    <= rx.v;
      out_pt.y    <= ry.v;
    end
  end

  `P2P_ASSERT_NOW(a_rem_below_den, vld[DIV_STAGES] && !zbad[DIV_STAGES] && !lane[DIV_STAGES][0].ovf, lane[DIV_STAGES][0].rem < den[DIV_STAGES])

endmodule

FILE: design/p2p_distort.sv
// Radial and tangential lens distortion; each stage either multiplies or forms saturating sums.
module p2p_distort import p2p_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  cam_cfg_t cfg,
  input  logic     in_valid,
  input  pt_t      in_pt,
  output logic     out_valid,
  output pt_t      out_pt
);

  logic [DIST_STAGES-1:0] vld;
  dctx_t c   [0:DIST_STAGES-1];
  dctx_t nxt [0:DIST_STAGES-1];

  always_comb begin
    sat_t sa;
    sat_t sb;
    sat_t sc;

    nxt[0]      = '0;
    nxt[0].zbad = in_pt.zbad;
    nxt[0].clip = in_pt.clip;
    nxt[0].x    = in_pt.x;
    nxt[0].y    = in_pt.y;
    nxt[0].m0   = in_pt.x * in_pt.x;
    nxt[0].m1   = in_pt.y * in_pt.y;

    nxt[1]      = c[0];
    sa          = sat32(40'(fsh(c[0].m0)) + 40'(fsh(c[0].m1)));
    nxt[1].r2   = sa.v;
    nxt[1].clip = c[0].clip | sa.clip;

    nxt[2]      = c[1];
    nxt[2].m0   = c[1].r2 * c[1].r2;
    nxt[2].m1   = cfg.k1 * c[1].r2;

    nxt[3]      = c[2];
    sa          = sat32(40'(fsh(c[2].m0)));
    nxt[3].r4   = sa.v;
    nxt[3].t1   = fsh(c[2].m1);
    nxt[3].clip = c[2].clip | sa.clip;

    nxt[4]      = c[3];
    nxt[4].m0   = c[3].r4 * c[3].r2;
    nxt[4].m1   = cfg.k2 * c[3].r4;

    nxt[5]      = c[4];
    sa          = sat32(40'(fsh(c[4].m0)));
    nxt[5].r6   = sa.v;
    nxt[5].t2   = fsh(c[4].m1);
    nxt[5].clip = c[4].clip | sa.clip;

    nxt[6]      = c[5];
    nxt[6].m0   = cfg.k3 * c[5].r6;

    nxt[7]      = c[6];
    sa          = sat32(40'(Q_ONE) + 40'(c[6].t1) + 40'(c[6].t2) + 40'(fsh(c[6].m0)));
    nxt[7].f    = sa.v;
    nxt[7].clip = c[6].clip | sa.clip;

    nxt[8]      = c[7];
    nxt[8].m0   = c[7].x * c[7].f;
    nxt[8].m1   = c[7].y * c[7].f;

    nxt[9]      = c[8];
    sa          = sat32(40'(fsh(c[8].m0)));
    sb          = sat32(40'(fsh(c[8].m1)));
    nxt[9].xr   = sa.v;
    nxt[9].yr   = sb.v;
    nxt[9].clip = c[8].clip | sa.clip | sb.clip;

    nxt[10]     = c[9];
    nxt[10].m0  = c[9].xr * c[9].xr;
    nxt[10].m1  = c[9].yr * c[9].yr;
    nxt[10].m2  = c[9].xr * c[9].yr;

    nxt[11]      = c[10];
    sa           = sat32(40'(fsh(c[10].m0)));
    sb           = sat32(40'(fsh(c[10].m1)));
    sc           = sat32(40'(fsh(c[10].m2)));
    nxt[11].xx   = sa.v;
    nxt[11].yy   = sb.v;
    nxt[11].xy   = sc.v;
    nxt[11].clip = c[10].clip | sa.clip | sb.clip | sc.clip;

    nxt[12]      = c[11];
    sa           = sat32(40'(c[11].r2) + (40'(c[11].xx) <<< 1));
    sb           = sat32(40'(c[11].r2) + (40'(c[11].yy) <<< 1));
    nxt[12].tx   = sa.v;
    nxt[12].ty   = sb.v;
    nxt[12].clip = c[11].clip | sa.clip | sb.clip;

    nxt[13]     = c[12];
    nxt[13].m0  = cfg.p1 * c[12].xy;
    nxt[13].m1  = cfg.p2 * c[12].tx;
    nxt[13].m2  = cfg.p2 * c[12].xy;
    nxt[13].m3  = cfg.p1 * c[12].ty;

    nxt[14]      = c[13];
    sa           = sat32(40'(c[13].xr) + (40'(fsh(c[13].m0)) <<< 1) + 40'(fsh(c[13].m1)));
    sb           = sat32(40'(c[13].yr) + (40'(fsh(c[13].m2)) <<< 1) + 40'(fsh(c[13].m3)));
    nxt[14].dx   = sa.v;
    nxt[14].dy   = sb.v;
    nxt[14].clip = c[13].clip | sa.clip | sb.clip;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DIST_STAGES-2:0], in_valid};
    end
  end

  assign out_valid   = vld[DIST_STAGES-1];
  assign out_pt.zbad = c[DIST_STAGES-1].zbad;
  assign out_pt.clip = c[DIST_STAGES-1].clip;
  assign out_pt.x    = c[DIST_STAGES-1].dx;
  assign out_pt.y    = c[DIST_STAGES-1].dy;

endmodule

FILE: design/p2p_pixel.sv
// Focal scaling, principal point offset and result status, ending in the output register.
module p2p_pixel import p2p_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  cam_cfg_t           cfg,
  input  logic               in_valid,
  input  pt_t                in_pt,
  output logic               out_valid,
  output logic signed [31:0] pixel_x,
  output logic signed [31:0] pixel_y,
  output logic [1:0]         status
);

  logic               mvld;
  logic               mzbad;
  logic               mclip;
  logic signed [64:0] mx;
  logic signed [64:0] my;
  sat_t               sx;
  sat_t               sy;

  always_ff @(posedge clk) begin
    if (adv) begin
      mzbad <= in_pt.zbad;
      mclip <= in_pt.clip;
      mx    <= in_pt.x * $signed({1'b0, cfg.fx});
      my    <= in_pt.y * $signed({1'b0, cfg.fy});
    end
  end

  assign sx = sat32(40'($signed(mx[64:FRAC])) + 40'(cfg.ppx));
  assign sy = sat32(40'($signed(my[64:FRAC])) + 40'(cfg.ppy));

  always_ff @(posedge clk) begin
    if (adv) begin
      if (mzbad) begin
        pixel_x <= '0;
        pixel_y <= '0;
        status  <= ST_DEPTH;
      end else begin
        pixel_x <= sx.v;
        pixel_y <= sy.v;
        status  <= (mclip | sx.clip | sy.clip) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mvld      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mvld      <= in_valid;
      out_valid <= mvld;
    end
  end

endmodule
